// File: src/u8d_pkg.sv
package u8d_pkg;

    localparam int CP_W       = 21;
    localparam int BYTE_W     = 8;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] LETTER_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;

    localparam logic [2:0] LEAD2_TAG = 3'h6;
    localparam logic [3:0] LEAD3_TAG = 4'hE;
    localparam logic [4:0] LEAD4_TAG = 5'h1E;

    // bytes released by the escape stage for one input beat
    typedef struct packed {
        logic              v0;
        logic [BYTE_W-1:0] b0;
        logic              v1;
        logic [BYTE_W-1:0] b1;
    } esc_feed_t;

    typedef struct packed {
        logic [1:0]      remaining;
        logic [CP_W-1:0] partial;
    } dec_state_t;

    typedef struct packed {
        dec_state_t      state;
        logic            hit;
        logic [CP_W-1:0] cp;
    } dec_step_t;

    typedef struct packed {
        logic            last;
        logic [CP_W-1:0] cp;
    } res_item_t;

    typedef struct packed {
        logic [1:0] count;
        res_item_t  item0;
        res_item_t  item1;
    } res_pair_t;

    // one byte through the lenient decoder
    function automatic dec_step_t dec_step(input dec_state_t st, input logic [BYTE_W-1:0] b);
        dec_step_t r;
        logic [CP_W-1:0] acc;
        r     = '0;
        r.state = st;
        acc   = {st.partial[CP_W-7:0], b[5:0]};
        if (st.remaining != 2'd0) begin
            r.state.remaining = st.remaining - 2'd1;
            r.state.partial   = acc;
            if (st.remaining == 2'd1) begin
                r.hit           = 1'b1;
                r.cp            = acc;
                r.state.partial = '0;
            end
        end else if (!b[7]) begin
            r.hit = 1'b1;
            r.cp  = {{(CP_W-BYTE_W){1'b0}}, b};
        end else if (b[7:5] == LEAD2_TAG) begin
            r.state.partial   = {{(CP_W-5){1'b0}}, b[4:0]};
            r.state.remaining = 2'd1;
        end else if (b[7:4] == LEAD3_TAG) begin
            r.state.partial   = {{(CP_W-4){1'b0}}, b[3:0]};
            r.state.remaining = 2'd2;
        end else if (b[7:3] == LEAD4_TAG) begin
            r.state.partial   = {{(CP_W-3){1'b0}}, b[2:0]};
            r.state.remaining = 2'd3;
        end
        return r;
    endfunction

endpackage

// File: src/u8d_escape.sv
module u8d_escape (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
    input  logic                      fin,
    output u8d_pkg::esc_feed_t        feed
);
    import u8d_pkg::*;

    logic held_reg;
    logic held_next;

    always_comb
    begin
        feed      = '0;
        held_next = 1'b0;
        if (held_reg) begin
            feed.v0 = 1'b1;
            if (byte_in == LETTER_N) begin
                feed.b0 = NEWLINE;
            end else begin
                feed.b0 = BACKSLASH;
                if (byte_in == BACKSLASH && !fin) begin
                    held_next = 1'b1;
                end else begin
                    feed.v1 = 1'b1;
                    feed.b1 = byte_in;
                end
            end
        end else if (byte_in == BACKSLASH && !fin) begin
            held_next = 1'b1;
        end else begin
            feed.v0 = 1'b1;
            feed.b0 = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else if (advance)
            held_reg <= held_next;
    end

endmodule

// File: src/u8d_decode.sv
module u8d_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               fin,
    input  u8d_pkg::esc_feed_t feed,
    output u8d_pkg::res_pair_t res
);
    import u8d_pkg::*;

    dec_state_t state_reg;
    dec_state_t state_next;
    dec_step_t  step0;
    dec_step_t  step1;
    dec_state_t mid;
    logic       hit0;
    logic       hit1;

    always_comb
    begin
        step0 = dec_step(state_reg, feed.b0);
        mid   = feed.v0 ? step0.state : state_reg;
        hit0  = feed.v0 && step0.hit;
        step1 = dec_step(mid, feed.b1);
        hit1  = feed.v1 && step1.hit;
        state_next = feed.v1 ? step1.state : mid;
        if (fin)
            state_next = '0;
    end

    // pack hits to the front; last flag on the final one
    always_comb
    begin
        res = '0;
        if (hit0 && hit1) begin
            res.count = 2'd2;
            res.item0 = '{last: 1'b0, cp: step0.cp};
            res.item1 = '{last: 1'b1, cp: step1.cp};
        end else if (hit0) begin
            res.count = 2'd1;
            res.item0 = '{last: 1'b1, cp: step0.cp};
        end else if (hit1) begin
            res.count = 2'd1;
            res.item0 = '{last: 1'b1, cp: step1.cp};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

endmodule

// File: src/u8d_out_fifo.sv
module u8d_out_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  u8d_pkg::res_pair_t          res,
    output logic                        room2,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [u8d_pkg::M_DATA_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import u8d_pkg::*;

    res_item_t         mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  push_n;
    logic              pop;
    res_item_t         head;

    assign head     = mem_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(M_DATA_W-CP_W){1'b0}}, head.cp};
    assign m_tlast  = head.last;
    assign pop      = m_tvalid && m_tready;
    assign room2    = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        push_n      = push ? CNT_W'(res.count) : '0;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push && res.count != 2'd0)
            mem_reg[wr_ptr_reg] <= res.item0;
        if (push && res.count == 2'd2)
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= res.item1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/utf8_decoder_with_newline_escape.sv
// channel | dir | tdata                  | tlast
// s_*     | in  | [7:0] text_byte        | final_byte
// m_*     | out | [20:0] code_point      | run_end (last result of its input beat)
//
// One input beat per clock while the output is not stalled and each byte gives
// at most one code point; a beat that gives two (held backslash released with
// its next byte) queues two results. Path: input register, then escape and
// decode logic into a 4-entry result queue, from which results leave.
// Reset clears the held backslash, the decode state and the queue.
// The input register advances only while the queue has room for two results.
module utf8_decoder_with_newline_escape (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [u8d_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] text_byte
    input  logic                         s_tlast,  // final_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [u8d_pkg::M_DATA_W-1:0] m_tdata,  // [20:0] code_point, rest zero
    output logic                         m_tlast   // run_end
);
    import u8d_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              advance;
    logic              room2;
    esc_feed_t         feed;
    res_pair_t         res;

    assign advance  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    u8d_escape u_escape (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (in_byte_reg),
        .fin     (in_last_reg),
        .feed    (feed)
    );

    u8d_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .fin     (in_last_reg),
        .feed    (feed),
        .res     (res)
    );

    u8d_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (advance),
        .res      (res),
        .room2    (room2),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
